// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/esd_pkg.sv =====
package esd_pkg;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX   = 3'd2,
        MODE_OCT   = 3'd3,
        MODE_SKIP  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_ZERO    = 2'd1,
        KIND_UNKNOWN = 2'd2
    } t_kind;

    // Character codes used by the escape decoder.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_X   = 8'h78;

    // Control codes produced by escapes.
    localparam logic [7:0] CC_BEL = 8'h07;
    localparam logic [7:0] CC_BS  = 8'h08;
    localparam logic [7:0] CC_HT  = 8'h09;
    localparam logic [7:0] CC_LF  = 8'h0A;
    localparam logic [7:0] CC_VT  = 8'h0B;
    localparam logic [7:0] CC_FF  = 8'h0C;
    localparam logic [7:0] CC_CR  = 8'h0D;

    // Digits gathered before a numeric escape closes by itself.
    localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;
    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
    } t_res;

    // Up to two results caused by one input beat.
    typedef struct packed {
        logic [1:0]  cnt;
        t_res        res0;
        t_res        res1;
    } t_res_pair;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  value;
        logic [1:0]  count;
    } t_scan;

    typedef struct packed {
        t_scan       scan;
        t_res_pair   pair;
    } t_dec;

    // Appends one result; a third result would be dropped.
    function automatic t_res_pair res_push(t_res_pair p, t_kind k, logic [7:0] b);
        t_res      r;
        t_res_pair q;
        r.kind = k;
        r.data = (k == KIND_BYTE) ? b : 8'h00;
        q = p;
        case (p.cnt)
            2'd0: begin
                q.res0 = r;
                q.cnt  = 2'd1;
            end
            2'd1: begin
                q.res1 = r;
                q.cnt  = 2'd2;
            end
            default: begin
                q = p;
            end
        endcase
        return q;
    endfunction

endpackage

// ===== design/esd_decode.sv =====
module esd_decode import esd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_take,
    input  logic [7:0] i_char,
    input  logic       i_eol,
    output t_res_pair  o_pair
);

    t_scan r_scan;
    t_scan n_scan;
    logic  r_crlf;

    // Closes a numeric escape: a zero value is an error and starts skipping.
    function automatic t_dec finish_numeric(t_dec d);
        t_dec q;
        q = d;
        if (d.scan.value == 8'h00) begin
            q.pair      = res_push(d.pair, KIND_ZERO, 8'h00);
            q.scan.mode = MODE_SKIP;
        end else begin
            q.pair      = res_push(d.pair, KIND_BYTE, d.scan.value);
            q.scan.mode = MODE_PLAIN;
        end
        q.scan.value = 8'h00;
        q.scan.count = 2'd0;
        return q;
    endfunction

    function automatic t_dec plain_char(t_dec d, logic [7:0] c);
        t_dec q;
        q = d;
        if (c == CH_NUL) begin
            q.scan.mode = MODE_SKIP;
        end else if (c == CH_BSLASH) begin
            q.scan.mode = MODE_ESC;
        end else begin
            q.pair      = res_push(d.pair, KIND_BYTE, c);
            q.scan.mode = MODE_PLAIN;
        end
        return q;
    endfunction

    function automatic t_dec escape_char(t_dec d, logic [7:0] c, logic crlf);
        t_dec q;
        q = d;
        q.scan.mode = MODE_PLAIN;
        unique case (c) inside
            CH_NUL:                       q.scan.mode = MODE_SKIP;
            CH_SQUOTE, CH_DQUOTE, CH_QMARK: q.pair = res_push(d.pair, KIND_BYTE, c);
            CH_BSLASH:                    q.pair = res_push(d.pair, KIND_BYTE, CH_BSLASH);
            CH_LC_A:                      q.pair = res_push(d.pair, KIND_BYTE, CC_BEL);
            CH_LC_B:                      q.pair = res_push(d.pair, KIND_BYTE, CC_BS);
            CH_LC_F:                      q.pair = res_push(d.pair, KIND_BYTE, CC_FF);
            CH_LC_N: begin
                if (crlf) begin
                    q.pair = res_push(q.pair, KIND_BYTE, CC_CR);
                end
                q.pair = res_push(q.pair, KIND_BYTE, CC_LF);
            end
            CH_LC_R:                      q.pair = res_push(d.pair, KIND_BYTE, CC_CR);
            CH_LC_T:                      q.pair = res_push(d.pair, KIND_BYTE, CC_HT);
            CH_LC_V:                      q.pair = res_push(d.pair, KIND_BYTE, CC_VT);
            CH_LC_X: begin
                q.scan.mode  = MODE_HEX;
                q.scan.value = 8'h00;
                q.scan.count = 2'd0;
            end
            [CH_0:CH_7]: begin
                q.scan.mode  = MODE_OCT;
                q.scan.value = {5'd0, c[2:0]};
                q.scan.count = 2'd1;
            end
            default:                      q.pair = res_push(d.pair, KIND_UNKNOWN, 8'h00);
        endcase
        return q;
    endfunction

    t_dec       d;
    logic       hex_ok;
    logic [3:0] hex_digit;
    logic       oct_ok;

    always_comb begin
        hex_ok    = 1'b0;
        hex_digit = i_char[3:0];
        if (i_char >= CH_0 && i_char <= CH_9) begin
            hex_ok = 1'b1;
        end else if ((i_char >= CH_UC_A && i_char <= CH_UC_F) ||
                     (i_char >= CH_LC_A && i_char <= CH_LC_F)) begin
            hex_ok    = 1'b1;
            hex_digit = i_char[3:0] + 4'd9;
        end
        oct_ok = (i_char >= CH_0) && (i_char <= CH_7);
    end

    always_comb begin
        d.scan = r_scan;
        d.pair = '0;
        unique case (r_scan.mode)
            MODE_ESC: begin
                d = escape_char(d, i_char, r_crlf);
            end
            MODE_HEX: begin
                if (hex_ok) begin
                    d.scan.value = {d.scan.value[3:0], hex_digit};
                    d.scan.count = d.scan.count + 2'd1;
                    if (d.scan.count >= HEX_MAX_DIGITS) begin
                        d = finish_numeric(d);
                    end
                end else begin
                    d = finish_numeric(d);
                    if (d.scan.mode != MODE_SKIP) begin
                        d = plain_char(d, i_char);
                    end
                end
            end
            MODE_OCT: begin
                if (oct_ok) begin
                    d.scan.value = {d.scan.value[4:0], i_char[2:0]};
                    d.scan.count = d.scan.count + 2'd1;
                    if (d.scan.count >= OCT_MAX_DIGITS) begin
                        d = finish_numeric(d);
                    end
                end else begin
                    d = finish_numeric(d);
                    if (d.scan.mode != MODE_SKIP) begin
                        d = plain_char(d, i_char);
                    end
                end
            end
            MODE_SKIP: begin
                d.scan = r_scan;
            end
            default: begin
                d = plain_char(d, i_char);
            end
        endcase

        // A line end closes any pending numeric escape and resets scanning.
        if (i_eol) begin
            if (d.scan.mode == MODE_HEX || d.scan.mode == MODE_OCT) begin
                d = finish_numeric(d);
            end
            d.scan.mode  = MODE_PLAIN;
            d.scan.value = 8'h00;
            d.scan.count = 2'd0;
        end

        n_scan = d.scan;
        o_pair = d.pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '{mode: MODE_PLAIN, value: 8'h00, count: 2'd0};
            r_crlf <= 1'b1;
        end else begin
            if (i_take) begin
                r_scan <= n_scan;
            end
            if (i_cfg_we) begin
                r_crlf <= i_cfg_wdata;
            end
        end
    end

endmodule

// ===== design/esd_out_stage.sv =====
module esd_out_stage import esd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_res_pair  i_pair,
    input  logic       i_stall,
    output logic       o_can_load,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    logic      r_valid;
    logic      r_sel;
    t_res_pair r_pair;
    t_res      cur;
    logic      last_beat;
    logic      out_done;

    assign last_beat  = r_sel || (r_pair.cnt != 2'd2);
    assign out_done   = r_valid && !i_stall && last_beat;
    assign o_can_load = !r_valid || out_done;

    assign cur        = r_sel ? r_pair.res1 : r_pair.res0;
    assign o_valid    = r_valid;
    assign o_kind     = cur.kind;
    assign o_out_byte = cur.data;
    assign o_run_last = last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (i_take) begin
            r_valid <= (i_pair.cnt != 2'd0);
            r_sel   <= 1'b0;
        end else if (out_done) begin
            r_valid <= 1'b0;
        end else if (r_valid && !i_stall) begin
            r_sel   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_pair <= i_pair;
        end
    end

endmodule

// ===== design/escape_sequence_decoder.sv =====
// A beat waits in the input register; its results go to the single-entry result
// register, which sends one beat a cycle unless stalled and so sets the rate: one
// input beat per cycle while the result channel does not stall and each item gives
// at most one result; a two-result item holds the input side until both go out.
// Reset is synchronous and active low: it clears the pipeline valids and the scan
// state, and sets newline_as_crlf to 1.
module escape_sequence_decoder import esd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration: newline_as_crlf.
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    // Input channel.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_line,
    // Result channel.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    // Input register. A beat sits here until the result register can take
    // everything that the beat produces.
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eol;

    logic       in_load;
    logic       take;
    logic       out_can_load;
    t_res_pair  dec_pair;

    // The held beat is decoded and consumed in the same cycle that the
    // result register is free or is sending its last beat. A beat that
    // yields no result (for example a backslash, or text being skipped)
    // is consumed as well and leaves the result register empty.
    assign take    = r_in_valid && out_can_load;
    assign o_stall = r_in_valid && !take;
    assign in_load = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_load || (r_in_valid && !take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_char <= i_char_code;
            r_in_eol  <= i_end_of_line;
        end
    end

    // Escape decoding and scan state. The scan state advances only when a
    // beat is consumed, so a stalled beat is never decoded twice.
    esd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_char      (r_in_char),
        .i_eol       (r_in_eol),
        .o_pair      (dec_pair)
    );

    // Result register. It holds both results of one item and sends them in
    // order; run_last marks the final beat of the item.
    esd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_pair      (dec_pair),
        .i_stall     (i_stall),
        .o_can_load  (out_can_load),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

endmodule

// ===== design/esd_checker.sv =====
`include "assert_macros.svh"

module esd_checker import esd_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_out_byte,
    input logic       o_run_last
);

    logic [10:0] out_beat;
    logic        flag_beat;

    assign out_beat  = {o_kind, o_out_byte, o_run_last};
    assign flag_beat = o_valid && (o_kind != KIND_BYTE);

    // A stalled result beat stays offered.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // A stalled result beat keeps its payload.
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(out_beat))

    // Error and warning beats carry a zero byte.
    `ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, flag_beat, o_out_byte == 8'h00)

    // Nothing of the same item follows an error or a warning.
    `ASSERT_IMPLY(a_err_last, i_clk, i_rst_n, flag_beat, o_run_last)

    // The second result of an item follows in the very next cycle.
    `ASSERT_NEXT(a_pair_next, i_clk, i_rst_n, o_valid && !i_stall && !o_run_last, o_valid)

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);

// ===== verif/tb_escape_sequence_decoder.sv =====
module tb_escape_sequence_decoder import esd_pkg::*; ();

    // Run control. The limit is far above the slowest legal run, even with the
    // heaviest stalling used here.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    // One character beat on the input channel.
    typedef struct packed {
        logic [7:0] code;
        logic       eol;
    } t_text_beat;

    // One decoded beat as the result channel should present it.
    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic       run_end;
    } t_decoded_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_char_code = 8'h00;
    logic       i_end_of_line = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic       o_run_last;

    escape_sequence_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_code   (i_char_code),
        .i_end_of_line (i_end_of_line),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last)
    );

    // Characters waiting to be offered, and decoded beats waiting to arrive.
    t_text_beat    text_beats_pending[$];
    t_decoded_beat expected_bytes[$];
    t_decoded_beat char_results[$];

    // Shadow copy of the decoder state and of its newline register.
    t_mode      scan_mode = MODE_PLAIN;
    logic [7:0] scan_value = 8'h00;
    logic [1:0] scan_count = 2'd0;
    logic       nl_crlf = 1'b1;

    // Idling rates in percent, set per phase by the sequencer.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_request = 1'b0;

    bit beat_taken = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow decoder. Results of one character are gathered first so that
    // the last of them can carry the run-end mark.
    // ------------------------------------------------------------------
    function automatic void push_decoded(t_kind k, logic [7:0] b);
        t_decoded_beat r;
        if (char_results.size() < 2) begin
            r.kind    = k;
            r.data    = (k == KIND_BYTE) ? b : 8'h00;
            r.run_end = 1'b0;
            char_results.push_back(r);
        end
    endfunction

    // Closes a numeric escape. A value of zero is illegal and skips the line.
    function automatic void close_numeric();
        if (scan_value == 8'h00) begin
            push_decoded(KIND_ZERO, 8'h00);
            scan_mode = MODE_SKIP;
        end else begin
            push_decoded(KIND_BYTE, scan_value);
            scan_mode = MODE_PLAIN;
        end
        scan_value = 8'h00;
        scan_count = 2'd0;
    endfunction

    // A character outside any escape. A NUL ends the text of the line.
    function automatic void plain_text(logic [7:0] c);
        if (c == CH_NUL) begin
            scan_mode = MODE_SKIP;
        end else if (c == CH_BSLASH) begin
            scan_mode = MODE_ESC;
        end else begin
            push_decoded(KIND_BYTE, c);
            scan_mode = MODE_PLAIN;
        end
    endfunction

    function automatic void decode_char(logic [7:0] c, logic eol);
        logic [7:0] nib;
        bit         is_hex;
        char_results.delete();
        case (scan_mode)
            MODE_ESC: begin
                scan_mode = MODE_PLAIN;
                case (c)
                    CH_NUL:                        scan_mode = MODE_SKIP;
                    CH_SQUOTE, CH_DQUOTE, CH_QMARK: push_decoded(KIND_BYTE, c);
                    CH_BSLASH:                     push_decoded(KIND_BYTE, CH_BSLASH);
                    CH_LC_A:                       push_decoded(KIND_BYTE, CC_BEL);
                    CH_LC_B:                       push_decoded(KIND_BYTE, CC_BS);
                    CH_LC_F:                       push_decoded(KIND_BYTE, CC_FF);
                    CH_LC_N: begin
                        if (nl_crlf) push_decoded(KIND_BYTE, CC_CR);
                        push_decoded(KIND_BYTE, CC_LF);
                    end
                    CH_LC_R:                       push_decoded(KIND_BYTE, CC_CR);
                    CH_LC_T:                       push_decoded(KIND_BYTE, CC_HT);
                    CH_LC_V:                       push_decoded(KIND_BYTE, CC_VT);
                    CH_LC_X: begin
                        scan_mode  = MODE_HEX;
                        scan_value = 8'h00;
                        scan_count = 2'd0;
                    end
                    default: begin
                        if (c >= CH_0 && c <= CH_7) begin
                            scan_mode  = MODE_OCT;
                            scan_value = c - CH_0;
                            scan_count = 2'd1;
                        end else begin
                            push_decoded(KIND_UNKNOWN, 8'h00);
                        end
                    end
                endcase
            end
            MODE_HEX: begin
                is_hex = 1'b1;
                nib    = 8'h00;
                if (c >= CH_0 && c <= CH_9) nib = c - CH_0;
                else if (c >= CH_UC_A && c <= CH_UC_F) nib = c - CH_UC_A + 8'd10;
                else if (c >= CH_LC_A && c <= CH_LC_F) nib = c - CH_LC_A + 8'd10;
                else is_hex = 1'b0;
                if (is_hex) begin
                    scan_value = {scan_value[3:0], nib[3:0]};
                    scan_count = scan_count + 2'd1;
                    if (scan_count >= HEX_MAX_DIGITS) close_numeric();
                end else begin
                    // The terminator completes the escape, then counts as text.
                    close_numeric();
                    if (scan_mode != MODE_SKIP) plain_text(c);
                end
            end
            MODE_OCT: begin
                if (c >= CH_0 && c <= CH_7) begin
                    nib        = c - CH_0;
                    scan_value = {scan_value[4:0], nib[2:0]};
                    scan_count = scan_count + 2'd1;
                    if (scan_count >= OCT_MAX_DIGITS) close_numeric();
                end else begin
                    close_numeric();
                    if (scan_mode != MODE_SKIP) plain_text(c);
                end
            end
            MODE_SKIP: begin
            end
            default: plain_text(c);
        endcase

        // Every line end closes a pending number and returns to plain text.
        if (eol) begin
            if (scan_mode == MODE_HEX || scan_mode == MODE_OCT) close_numeric();
            scan_mode  = MODE_PLAIN;
            scan_value = 8'h00;
            scan_count = 2'd0;
        end

        if (char_results.size() != 0) char_results[char_results.size() - 1].run_end = 1'b1;
        foreach (char_results[i]) expected_bytes.push_back(char_results[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void queue_text_beat(logic [7:0] c, logic eol);
        t_text_beat b;
        b.code = c;
        b.eol  = eol;
        text_beats_pending.push_back(b);
    endfunction

    // Builds one text line out of random tokens: plain text, simple, hex and octal
    // escapes, unknown escapes, lone backslashes and raw bytes.
    function automatic int queue_random_line();
        logic [7:0] text[$];
        logic [7:0] c;
        int         n_tok;
        int         pick;
        int         n_dig;
        int         d;
        bit         zeros;
        n_tok = $urandom_range(1, 6);
        repeat (n_tok) begin
            pick  = $urandom_range(0, 99);
            zeros = ($urandom_range(0, 4) == 0);
            if (pick < 30) begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                text.push_back((c == CH_BSLASH) ? CH_UC_A : c);
            end else if (pick < 50) begin
                text.push_back(CH_BSLASH);
                case ($urandom_range(0, 10))
                    0:       c = CH_SQUOTE;
                    1:       c = CH_DQUOTE;
                    2:       c = CH_QMARK;
                    3:       c = CH_BSLASH;
                    4:       c = CH_LC_A;
                    5:       c = CH_LC_B;
                    6:       c = CH_LC_F;
                    7:       c = CH_LC_N;
                    8:       c = CH_LC_R;
                    9:       c = CH_LC_T;
                    default: c = CH_LC_V;
                endcase
                text.push_back(c);
            end else if (pick < 65) begin
                text.push_back(CH_BSLASH);
                text.push_back(CH_LC_X);
                n_dig = $urandom_range(0, 2);
                repeat (n_dig) begin
                    d = zeros ? 0 : $urandom_range(0, 15);
                    if (d < 10) c = CH_0 + 8'(d);
                    else if ($urandom_range(0, 1) == 1) c = CH_UC_A + 8'(d - 10);
                    else c = CH_LC_A + 8'(d - 10);
                    text.push_back(c);
                end
            end else if (pick < 80) begin
                text.push_back(CH_BSLASH);
                n_dig = $urandom_range(1, 3);
                repeat (n_dig) text.push_back(zeros ? CH_0 : CH_0 + 8'($urandom_range(0, 7)));
            end else if (pick < 88) begin
                text.push_back(CH_BSLASH);
                text.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (pick < 92) begin
                text.push_back(CH_BSLASH);
            end else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (text[i]) queue_text_beat(text[i], i == text.size() - 1);
        return text.size();
    endfunction

    // The register is written only while the decoder is idle.
    task automatic write_crlf(logic v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        nl_crlf = v;
    endtask

    // Waits until every character is taken and every result has arrived, then
    // lets the pipeline settle for characters that produce no result.
    task automatic wait_drained();
        while (text_beats_pending.size() != 0 || i_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(logic crlf, int tx_pct, int rx_pct, int n_items);
        int queued;
        queued = 0;
        write_crlf(crlf);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (queued < n_items) queued += queue_random_line();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequencer: reset, directed lines, then random phases at several
    // register settings and idling profiles.
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_crlf(1'b1);
        tx_idle_pct = 16;
        rx_idle_pct = 68;

        queue_text_beat(8'hFF, 1'b0);
        // Newline escape gives two beats with the register set.
        queue_text_beat(CH_BSLASH, 1'b0);
        queue_text_beat(CH_LC_N, 1'b0);
        queue_text_beat(CH_BSLASH, 1'b0);
        queue_text_beat(CH_SQUOTE, 1'b0);
        // Two hex digits of mixed case close the escape by themselves.
        queue_text_beat(CH_BSLASH, 1'b0);
        queue_text_beat(CH_LC_X, 1'b0);
        queue_text_beat(CH_LC_A, 1'b0);
        queue_text_beat("B", 1'b0);
        // Three octal sevens wrap to an all-ones byte.
        queue_text_beat(CH_BSLASH, 1'b0);
        queue_text_beat(CH_7, 1'b0);
        queue_text_beat(CH_7, 1'b0);
        queue_text_beat(CH_7, 1'b0);
        // Unknown escape letter.
        queue_text_beat(CH_BSLASH, 1'b0);
        queue_text_beat("q", 1'b0);
        // A terminator ends an octal escape and then passes as text.
        queue_text_beat(CH_BSLASH, 1'b0);
        queue_text_beat("1", 1'b0);
        queue_text_beat("G", 1'b0);
        // A hex escape with no digits is the zero error; the line is skipped.
        queue_text_beat(CH_BSLASH, 1'b0);
        queue_text_beat(CH_LC_X, 1'b0);
        queue_text_beat("g", 1'b0);
        queue_text_beat("z", 1'b1);
        // A backslash at the end of a line is dropped.
        queue_text_beat(CH_BSLASH, 1'b1);
        // The line end completes a hex escape with no digits.
        queue_text_beat(CH_BSLASH, 1'b0);
        queue_text_beat(CH_LC_X, 1'b1);
        // A NUL character hides the rest of its line.
        queue_text_beat(8'h01, 1'b0);
        queue_text_beat(CH_NUL, 1'b0);
        queue_text_beat(CH_UC_A, 1'b1);
        // A NUL after a backslash is dropped silently.
        queue_text_beat(CH_BSLASH, 1'b0);
        queue_text_beat(CH_NUL, 1'b1);
        wait_drained();

        run_random_phase(1'b0, 16, 68, 550);
        run_random_phase(1'b1, 68, 16, 550);
        // The receiver holds off at the start of this phase while the sender
        // keeps offering beats, so the decoder fills up and stalls its input.
        hold_request = 1'b1;
        run_random_phase(1'b0, 0, 0, 275);
        run_random_phase(1'b1, 0, 0, 275);

        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("tb_escape_sequence_decoder OK");
        end else begin
            $display("tb_escape_sequence_decoder NOT OK");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver. A new beat is put up at the falling edge only when the
    // previous one was taken or none was on offer; a stalled beat holds.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || beat_taken) begin
            if (text_beats_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                i_valid       <= 1'b1;
                i_char_code   <= text_beats_pending[0].code;
                i_end_of_line <= text_beats_pending[0].eol;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // A beat accepted at this edge runs through the shadow decoder at once.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            decode_char(i_char_code, i_end_of_line);
            void'(text_beats_pending.pop_front());
            beat_taken <= 1'b1;
        end else begin
            beat_taken <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall. The long hold-off is counted down here, one cycle per
    // falling edge; otherwise the stall is random at the phase's rate.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : rx_stall_gen
        int  hold_left;
        bit  hold_done;
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_request && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Each beat taken from the decoder is checked field by
    // field against the oldest expected beat.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_decoded_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bytes.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result beat: kind %0d byte %02h run_last %0b",
                             o_kind, o_out_byte, o_run_last);
            end else begin
                want = expected_bytes.pop_front();
                if (o_kind !== want.kind || o_out_byte !== want.data
                        || o_run_last !== want.run_end) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("result mismatch: expected kind %0d byte %02h run_last %0b",
                                 want.kind, want.data, want.run_end);
                        $display("                 got kind %0d byte %02h run_last %0b",
                                 o_kind, o_out_byte, o_run_last);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_escape_sequence_decoder NOT OK");
            $finish;
        end
    end

endmodule
